>>> sv/lpfd_pkg.sv
// ----------------------------------------------------------------------------
// lpfd_pkg
// Types and constants shared by the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package lpfd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W  = 16;
	localparam int unsigned KIND_W = 2;

	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd1024;

	localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EMPTY    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_OVERSIZE = 2'd2;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              chunk_last;
	} in_item_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] payload_byte;
		logic              frame_last;
	} out_item_t;

endpackage

>>> sv/length_prefixed_frame_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer
// Reassembles frames with a 2-byte big-endian length prefix from a byte
// stream and passes the payload bytes out, with a result for each empty or oversize frame, one result per byte at most.
// ----------------------------------------------------------------------------
// The block takes one byte per clock cycle while the skid slot is not full,
// and gives at most one result per byte. A byte passes through the input register
// and then the result register, with a single-entry skid slot behind the
// result register so that a stalled output does not stall the input until the
// skid slot fills. All header, payload and discard logic is one short update
// between those registers. There is no clearing pass after reset.
module length_prefixed_frame_deframer
	import lpfd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// received byte channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	// max_frame_len write channel
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [LEN_W-1:0]     cfg_data
);

	localparam logic [1:0] PH_LEN_HIGH = 2'd0;
	localparam logic [1:0] PH_LEN_LOW  = 2'd1;
	localparam logic [1:0] PH_PAYLOAD  = 2'd2;
	localparam logic [1:0] PH_DISCARD  = 2'd3;

	logic [LEN_W-1:0]  max_len_q;
	logic [1:0]        phase_q;
	logic [BYTE_W-1:0] len_high_q;
	logic [LEN_W-1:0]  bytes_left_q;

	logic              valid_s1;
	in_item_t          item_s1;

	logic              res_vld_q;
	out_item_t         res_q;
	logic              skid_vld_q;
	out_item_t         skid_q;

	logic              in_xfer;
	logic              s1_go;
	logic              res_free;
	logic              gen;
	out_item_t         new_res;
	logic [1:0]        phase_d;
	logic [BYTE_W-1:0] len_high_d;
	logic [LEN_W-1:0]  bytes_left_d;
	logic [LEN_W-1:0]  hdr_len;

	assign cfg_ready = 1'b1;
	assign in_stall  = valid_s1 && skid_vld_q;
	assign in_xfer   = in_valid && !in_stall;
	assign s1_go     = valid_s1 && !skid_vld_q;
	assign res_free  = !res_vld_q || !out_stall;
	assign out_valid = res_vld_q;
	assign out_data  = res_q;
	assign hdr_len   = {len_high_q, item_s1.data_byte};

	always_comb begin
		phase_d      = phase_q;
		len_high_d   = len_high_q;
		bytes_left_d = bytes_left_q;
		gen          = 1'b0;
		new_res      = '0;
		case (phase_q)
			PH_LEN_LOW: begin
				if (hdr_len == '0) begin
					phase_d            = PH_LEN_HIGH;
					gen                = 1'b1;
					new_res.kind       = KIND_EMPTY;
					new_res.frame_last = 1'b1;
				end else if (hdr_len > max_len_q) begin
					phase_d      = PH_DISCARD;
					bytes_left_d = '0;
					gen          = 1'b1;
					new_res.kind = KIND_OVERSIZE;
				end else begin
					phase_d      = PH_PAYLOAD;
					bytes_left_d = hdr_len;
				end
			end
			PH_PAYLOAD: begin
				bytes_left_d         = bytes_left_q - LEN_W'(1);
				gen                  = 1'b1;
				new_res.kind         = KIND_PAYLOAD;
				new_res.payload_byte = item_s1.data_byte;
				if (bytes_left_q == LEN_W'(1)) begin
					phase_d            = PH_LEN_HIGH;
					new_res.frame_last = 1'b1;
				end
			end
			PH_DISCARD: begin
				// drop bytes through the end of the chunk
				if (item_s1.chunk_last) begin
					phase_d = PH_LEN_HIGH;
				end
			end
			default: begin
				len_high_d = item_s1.data_byte;
				phase_d    = PH_LEN_LOW;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_LEN_HIGH;
			len_high_q   <= '0;
			bytes_left_q <= '0;
		end else if (s1_go) begin
			phase_q      <= phase_d;
			len_high_q   <= len_high_d;
			bytes_left_q <= bytes_left_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1 <= in_data;
		end
	end

	// result register with skid slot; the skid entry is always the newer one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (res_free) begin
			if (skid_vld_q) begin
				res_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				res_vld_q  <= s1_go && gen;
			end
		end else if (s1_go && gen) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free) begin
			if (skid_vld_q) begin
				res_q <= skid_q;
			end else begin
				res_q <= new_res;
			end
		end else if (s1_go && gen) begin
			skid_q <= new_res;
		end
	end

	skid_needs_res: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> res_vld_q)
		else $error("skid slot holds a result while the result register is empty");

	oversize_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.kind == KIND_OVERSIZE) |->
		(!out_data.frame_last && out_data.payload_byte == '0))
		else $error("oversize result carries payload or last mark");

	payload_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (bytes_left_q != '0))
		else $error("payload phase with no bytes left");

	empty_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && phase_q == PH_LEN_LOW && hdr_len == '0) |=>
		(phase_q == PH_LEN_HIGH))
		else $error("empty frame did not return to header phase");

endmodule

>>> tb/tb_length_prefixed_frame_deframer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_length_prefixed_frame_deframer
// Self-checking bench for the deframer. Feeds header, payload, oversize and
// discard sequences under several max_frame_len values and idle patterns.
// An in-bench frame tracker predicts each result, and a scoreboard compares
// the results field by field, in order.
// ----------------------------------------------------------------------------
module tb_length_prefixed_frame_deframer
	import lpfd_pkg::*;
();

	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned SETTLE_CYCLES = 6;

	typedef enum logic [1:0] {
		WAIT_LEN_HI,
		WAIT_LEN_LO,
		IN_PAYLOAD,
		DROPPING
	} rx_phase_t;

	// Tracks the frame state and holds the results still owed by the block.
	class frame_scoreboard;
		logic [LEN_W-1:0]  max_len;
		rx_phase_t         phase;
		logic [BYTE_W-1:0] len_hi;
		logic [LEN_W-1:0]  remaining;
		out_item_t         owed_q[$];
		int unsigned       errors;

		function new();
			max_len = MAX_LEN_RESET;
			phase = WAIT_LEN_HI;
			len_hi = '0;
			remaining = '0;
			errors = 0;
		endfunction

		function void set_max_len(logic [LEN_W-1:0] v);
			max_len = v;
		endfunction

		function void note_byte(in_item_t item);
			logic [LEN_W-1:0] hdr_len;
			out_item_t        res;
			res = '0;
			hdr_len = {len_hi, item.data_byte};
			case (phase)
			WAIT_LEN_LO: begin
				if (hdr_len == '0) begin
					phase = WAIT_LEN_HI;
					res.kind = KIND_EMPTY;
					res.frame_last = 1'b1;
					owed_q.push_back(res);
				end else if (hdr_len > max_len) begin
					phase = DROPPING;
					remaining = '0;
					res.kind = KIND_OVERSIZE;
					owed_q.push_back(res);
				end else begin
					remaining = hdr_len;
					phase = IN_PAYLOAD;
				end
			end
			IN_PAYLOAD: begin
				remaining = remaining - 1'b1;
				res.kind = KIND_PAYLOAD;
				res.payload_byte = item.data_byte;
				res.frame_last = (remaining == '0);
				if (remaining == '0)
					phase = WAIT_LEN_HI;
				owed_q.push_back(res);
			end
			DROPPING: begin
				if (item.chunk_last)
					phase = WAIT_LEN_HI;
			end
			default: begin
				len_hi = item.data_byte;
				phase = WAIT_LEN_LO;
			end
			endcase
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (owed_q.size() == 0) begin
				$error("unexpected result: kind %0d payload_byte 0x%02h frame_last %0b",
					got.kind, got.payload_byte, got.frame_last);
				errors++;
				return;
			end
			want = owed_q.pop_front();
			if (got.kind !== want.kind) begin
				$error("kind: expected %0d, got %0d", want.kind, got.kind);
				errors++;
			end
			if (got.payload_byte !== want.payload_byte) begin
				$error("payload_byte: expected 0x%02h, got 0x%02h",
					want.payload_byte, got.payload_byte);
				errors++;
			end
			if (got.frame_last !== want.frame_last) begin
				$error("frame_last: expected %0b, got %0b", want.frame_last, got.frame_last);
				errors++;
			end
		endfunction

		function int pending();
			return owed_q.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	in_item_t         in_data;
	logic             out_valid;
	logic             out_stall;
	out_item_t        out_data;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [LEN_W-1:0] cfg_data;

	frame_scoreboard sb;
	int unsigned     sent_bytes;
	int unsigned     quiet_cycles;
	int unsigned     in_idle_pct;
	int unsigned     out_stall_pct;

	length_prefixed_frame_deframer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < out_stall_pct);
	end

	// Observe every transfer at the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.set_max_len(cfg_data);
			if (in_valid && !in_stall) begin
				sb.note_byte(in_data);
				sent_bytes++;
			end
			if (out_valid && !out_stall)
				sb.check_result(out_data);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
					(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Called and returns at a falling edge.
	task automatic push_byte(input logic [BYTE_W-1:0] b, input logic cl);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{data_byte: b, chunk_last: cl};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [BYTE_W-1:0] rand_byte();
		return BYTE_W'($urandom_range(255));
	endfunction

	function automatic logic chunk_end_roll();
		return ($urandom_range(99) < 15);
	endfunction

	task automatic drop_chunk();
		repeat ($urandom_range(0, 4))
			push_byte(rand_byte(), 1'b0);
		push_byte(rand_byte(), 1'b1);
	endtask

	// Wait until the block is empty, then let in-flight bytes settle.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	task automatic write_max_len(input logic [LEN_W-1:0] v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Emit one step of traffic: finish an open frame, header or discard, or start a new one.
	task automatic emit_frame();
		int  len;
		int  cut;
		int  pick;
		bit  messy;
		messy = (sb.max_len <= 64);
		case (sb.phase)
		IN_PAYLOAD: begin
			len = sb.remaining;
			repeat (len)
				push_byte(rand_byte(), chunk_end_roll());
		end
		WAIT_LEN_LO: begin
			push_byte(rand_byte(), chunk_end_roll());
		end
		DROPPING: begin
			drop_chunk();
		end
		default: begin
			if (messy && $urandom_range(99) < 8) begin
				repeat ($urandom_range(1, 4))
					push_byte(rand_byte(), chunk_end_roll());
			end else begin
				pick = $urandom_range(99);
				if (pick < 40)
					len = $urandom_range(0, 6);
				else if (pick < 60 && messy)
					len = sb.max_len + $urandom_range(0, 1);
				else if (pick < 75)
					len = ($urandom_range(3) == 0) ? 16'hFFFF : $urandom_range(16'hFFFF);
				else
					len = $urandom_range(7, 40);
				// keep accepted frames short
				if (len <= sb.max_len && len > 64)
					len = len % 65;
				push_byte(len[15:8], chunk_end_roll());
				push_byte(len[7:0], $urandom_range(99) < 30);
				if (len > sb.max_len) begin
					drop_chunk();
				end else if (len != 0) begin
					cut = len;
					if (messy && $urandom_range(99) < 6)
						cut = $urandom_range(0, len - 1);
					repeat (cut)
						push_byte(rand_byte(), chunk_end_roll());
					// a truncated frame runs straight into the next header
					if (cut != len) begin
						push_byte(rand_byte(), chunk_end_roll());
						push_byte(rand_byte(), chunk_end_roll());
					end
				end
			end
		end
		endcase
	endtask

	task automatic run_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
			input int unsigned count, input bit end_mid_frame);
		int unsigned start;
		in_idle_pct = idle_pct;
		out_stall_pct = stall_pct;
		start = sent_bytes;
		while (sent_bytes - start < count || (!end_mid_frame && sb.phase != WAIT_LEN_HI))
			emit_frame();
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_idle_pct = 0;
		out_stall_pct = 0;
		sent_bytes = 0;
		quiet_cycles = 0;
		sb = new();
		repeat (5)
			@(negedge clk);
		arst_n = 1'b1;

		// empty frame
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b0);
		// one-byte frame, all ones, ending a chunk
		push_byte(8'h00, 1'b0);
		push_byte(8'h01, 1'b0);
		push_byte(8'hFF, 1'b1);
		// three-byte frame spanning a chunk end
		push_byte(8'h00, 1'b0);
		push_byte(8'h03, 1'b1);
		push_byte(8'h00, 1'b0);
		push_byte(8'hA5, 1'b1);
		push_byte(8'h5A, 1'b0);
		// oversize mid-chunk: drop the rest of this chunk
		push_byte(8'h04, 1'b0);
		push_byte(8'h01, 1'b0);
		push_byte(8'h11, 1'b0);
		push_byte(8'h22, 1'b1);
		// oversize on a chunk end: drop the whole next chunk
		push_byte(8'hFF, 1'b0);
		push_byte(8'hFF, 1'b1);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b1);
		// two-byte frame after the drop
		push_byte(8'h00, 1'b0);
		push_byte(8'h02, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'h7F, 1'b1);

		write_max_len(16'd16);
		run_traffic(0, 0, 220, 1'b1);
		// the open frame, if any, completes under a limit of zero
		write_max_len(16'd0);
		run_traffic(45, 0, 160, 1'b0);
		write_max_len(16'hFFFF);
		run_traffic(0, 45, 220, 1'b0);
		write_max_len(LEN_W'($urandom_range(1, 48)));
		run_traffic(8, 8, 220, 1'b0);

		settle();
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
